[rtl/mfrf_pkg.sv]
// ----------------------------------------------------------------------------
// mfrf_pkg
// Shared types, constants and the byte-wide CRC-16 for the frame receive filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrf_pkg;

    localparam int MAX_PAYLOAD   = 116;
    localparam int HEADER_LEN    = 9;
    localparam int MIN_FRAME_LEN = 11;
    localparam int LAST_PAY_POS  = MIN_FRAME_LEN + MAX_PAYLOAD - 1;

    localparam int POS_W   = 8;
    localparam int COUNT_W = 7;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'h0000;
    localparam logic [15:0] BROADCAST_ID = 16'hFFFF;
    localparam int          ACK_REQ_BIT  = 5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_FCS_ERR  = 3'd3;
    localparam logic [2:0] ST_PAN_MISS = 3'd4;
    localparam logic [2:0] ST_DST_MISS = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int REG_ADDR_W  = 3;
    localparam logic REG_OWN_PAN  = 1'b0;
    localparam logic REG_OWN_ADDR = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_rx_in;

    typedef struct packed {
        logic               item_kind;
        logic [7:0]         payload_byte;
        logic [2:0]         status;
        logic [15:0]        frame_control;
        logic [7:0]         seq_number;
        logic [15:0]        frame_pan;
        logic [15:0]        frame_dst;
        logic [15:0]        frame_src;
        logic [COUNT_W-1:0] payload_count;
        logic [15:0]        frame_check;
        logic               ack_request;
        logic [15:0]        ack_check;
    } t_rx_out;

    typedef struct packed {
        logic [15:0] own_pan;
        logic [15:0] own_address;
    } t_cfg;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    localparam logic [15:0] ACK_SEED = crc_byte(crc_byte(CRC_INIT, 8'h02), 8'h00);

endpackage

`default_nettype wire

[rtl/mfrf_cfg.sv]
// ----------------------------------------------------------------------------
// mfrf_cfg
// Register file for the own PAN and own short address, written over APB.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrf_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mfrf_pkg::REG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output mfrf_pkg::t_cfg                        o_cfg
);
    import mfrf_pkg::*;

    logic [15:0] r_own_pan;
    logic [15:0] r_own_addr;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_pan  <= '0;
            r_own_addr <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_OWN_PAN:  r_own_pan  <= pwdata[15:0];
                REG_OWN_ADDR: r_own_addr <= pwdata[15:0];
                default:      r_own_pan  <= r_own_pan;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_OWN_PAN:  prdata = {16'h0000, r_own_pan};
            REG_OWN_ADDR: prdata = {16'h0000, r_own_addr};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.own_pan     = r_own_pan;
    assign o_cfg.own_address = r_own_addr;

endmodule

`default_nettype wire

[rtl/mfrf_parse.sv]
// ----------------------------------------------------------------------------
// mfrf_parse
// Byte position, header capture, two-byte delay line and running CRC; forms
// up to two results (payload byte, then frame summary) for each byte taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrf_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire mfrf_pkg::t_rx_in  i_data,
    input  wire mfrf_pkg::t_cfg    i_cfg,
    output logic [1:0]             o_num,
    output mfrf_pkg::t_rx_out      o_res0,
    output mfrf_pkg::t_rx_out      o_res1
);
    import mfrf_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic [7:0]       r_dly [2];
    logic [7:0]       r_hdr [HEADER_LEN];

    logic [POS_W-1:0] pos_plus;
    logic [15:0]      crc_upd;
    logic [15:0]      n_crc;
    logic [POS_W-1:0] n_pos;
    logic             pay_emit;
    logic [15:0]      fc;
    logic [15:0]      pan;
    logic [15:0]      dst;
    logic [15:0]      fcs;
    logic [POS_W-1:0] plen;
    logic             too_long;
    t_rx_out          pay_res;
    t_rx_out          sum_res;

    assign pos_plus = r_pos + POS_W'(1);
    assign crc_upd  = (r_pos >= POS_W'(2)) ? crc_byte(r_crc, r_dly[1]) : r_crc;
    assign pay_emit = (r_pos >= POS_W'(MIN_FRAME_LEN)) && (r_pos <= POS_W'(LAST_PAY_POS));

    assign fc       = {r_hdr[1], r_hdr[0]};
    assign pan      = {r_hdr[4], r_hdr[3]};
    assign dst      = {r_hdr[6], r_hdr[5]};
    assign fcs      = {i_data.in_byte, r_dly[0]};
    assign plen     = r_pos - POS_W'(MIN_FRAME_LEN - 1);
    assign too_long = (r_pos == POS_MAX) || (r_pos > POS_W'(LAST_PAY_POS));

    always_comb begin
        pay_res              = '0;
        pay_res.item_kind    = KIND_PAYLOAD;
        pay_res.payload_byte = r_dly[1];
    end

    always_comb begin
        sum_res           = '0;
        sum_res.item_kind = KIND_SUMMARY;
        if (r_pos < POS_W'(MIN_FRAME_LEN - 1)) begin
            sum_res.status = ST_SHORT;
        end else begin
            if (too_long) begin
                sum_res.status = ST_TOO_LONG;
            end else if (fcs != crc_upd) begin
                sum_res.status = ST_FCS_ERR;
            end else if (pan != i_cfg.own_pan && pan != BROADCAST_ID) begin
                sum_res.status = ST_PAN_MISS;
            end else if (dst != i_cfg.own_address && dst != BROADCAST_ID) begin
                sum_res.status = ST_DST_MISS;
            end else begin
                sum_res.status = ST_OK;
            end
            sum_res.frame_control = fc;
            sum_res.seq_number    = r_hdr[2];
            sum_res.frame_pan     = pan;
            sum_res.frame_dst     = dst;
            sum_res.frame_src     = {r_hdr[8], r_hdr[7]};
            sum_res.payload_count = too_long ? COUNT_W'(MAX_PAYLOAD) : plen[COUNT_W-1:0];
            sum_res.frame_check   = fcs;
            sum_res.ack_request   = (sum_res.status == ST_OK) && fc[ACK_REQ_BIT];
            sum_res.ack_check     = crc_byte(ACK_SEED, r_hdr[2]);
        end
    end

    always_comb begin
        o_res0 = pay_emit ? pay_res : sum_res;
        o_res1 = sum_res;
        if (!i_take) begin
            o_num = 2'd0;
        end else begin
            o_num = 2'(pay_emit) + 2'(i_data.last_byte);
        end
    end

    always_comb begin
        if (i_data.last_byte) begin
            n_pos = '0;
            n_crc = CRC_INIT;
        end else begin
            n_pos = (r_pos == POS_MAX) ? r_pos : pos_plus;
            n_crc = crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else if (i_take) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_dly[0] <= i_data.in_byte;
            r_dly[1] <= r_dly[0];
            for (int i = 0; i < HEADER_LEN; i++) begin
                if (r_pos == POS_W'(i)) begin
                    r_hdr[i] <= i_data.in_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/mfrf_out_fifo.sv]
// ----------------------------------------------------------------------------
// mfrf_out_fifo
// Small result queue: takes zero, one or two results a cycle, hands out one while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrf_out_fifo (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [1:0]                        i_num,
    input  wire mfrf_pkg::t_rx_out                 i_res0,
    input  wire mfrf_pkg::t_rx_out                 i_res1,
    output logic                                   o_full2,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output mfrf_pkg::t_rx_out                      o_out_data
);
    import mfrf_pkg::*;

    t_rx_out               r_mem [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] r_head;
    logic [FIFO_IDX_W-1:0] r_tail;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;
    logic [FIFO_IDX_W-1:0] tail_next;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_head];
    assign pop         = o_out_valid & ~i_out_stall;
    assign o_full2     = (r_count > FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign tail_next   = r_tail + FIFO_IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + FIFO_IDX_W'(pop);
            r_tail  <= r_tail + FIFO_IDX_W'(i_num);
            r_count <= r_count + FIFO_CNT_W'(i_num) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_num != 2'd0) begin
            r_mem[r_tail] <= i_res0;
        end
        if (i_num == 2'd2) begin
            r_mem[tail_next] <= i_res1;
        end
    end

endmodule

`default_nettype wire

[rtl/mac_frame_receive_filter.sv]
// ----------------------------------------------------------------------------
// mac_frame_receive_filter
// Receive filter for short-address MAC frames: parses the header, forwards
// payload bytes, checks the FCS and reports a per-frame summary.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (t_rx_in)
//   output    out        o_out_valid / i_out_stall  o_out_data (t_rx_out)
//   config    in         APB psel/penable/pready    pwdata / prdata
//
// One byte is taken per cycle unless stalled; its results are queued in the
// cycle after. A final byte that also releases a payload byte yields two
// results, which leave payload first. The input stalls while fewer than two
// queue entries are free. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_frame_receive_filter (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire mfrf_pkg::t_rx_in                 i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output mfrf_pkg::t_rx_out                     o_out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mfrf_pkg::REG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);
    import mfrf_pkg::*;

    t_cfg       cfg;
    logic       take;
    logic       full2;
    logic [1:0] num;
    t_rx_out    res0;
    t_rx_out    res1;

    assign o_in_stall = full2;
    assign take       = i_in_valid & ~full2;

    mfrf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mfrf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_in_data),
        .i_cfg   (cfg),
        .o_num   (num),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    mfrf_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num       (num),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_full2     (full2),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[tb/mac_frame_receive_filter_tb.sv]
// ----------------------------------------------------------------------------
// mac_frame_receive_filter_tb
// Self-checking testbench for the MAC frame receive filter. A short table of
// frames runs first, then random frames in several filter settings: mostly
// well-formed headers with a correct FCS, mixed with short, overlong, corrupt
// and noise frames. Each accepted byte goes through a predictor of the
// filter, and each output transfer is compared with the oldest expected item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mac_frame_receive_filter_tb;

    import mfrf_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int NUM_PHASES      = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_FRAME       = 300;

    localparam logic [REG_ADDR_W-1:0] ADDR_OWN_PAN  = {REG_OWN_PAN, 2'b00};
    localparam logic [REG_ADDR_W-1:0] ADDR_OWN_ADDR = {REG_OWN_ADDR, 2'b00};

    // Each row holds the byte, the last-byte mark and whether a short-frame
    // summary is expected as is.
    localparam int DIRECTED_LEN = 22;
    localparam logic [9:0] DIRECTED_ROWS [DIRECTED_LEN] = '{
        {8'hFF, 1'b1, 1'b1},
        {8'h00, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0}, {8'h55, 1'b0, 1'b0},
        {8'hAA, 1'b0, 1'b0}, {8'h01, 1'b0, 1'b0}, {8'h80, 1'b0, 1'b0},
        {8'hFE, 1'b0, 1'b0}, {8'h7F, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
        {8'hFF, 1'b1, 1'b1},
        {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
        {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
        {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
        {8'h00, 1'b0, 1'b0}, {8'h00, 1'b1, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_rx_in                i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_rx_out               o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    logic                  short_end_mark;

    t_rx_out               rx_items_due [$];
    int                    error_count = 0;
    int                    quiet_cycles = 0;
    int                    bytes_sent = 0;

    logic [15:0]           own_pan_q;
    logic [15:0]           own_addr_q;
    logic [POS_W-1:0]      byte_pos;
    logic [15:0]           crc_acc;
    logic [7:0]            delay_q [2];
    logic [7:0]            hdr_q [HEADER_LEN];

    mac_frame_receive_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            feedback = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic t_rx_out short_summary();
        t_rx_out r;
        r = '0;
        r.item_kind = KIND_SUMMARY;
        r.status    = ST_SHORT;
        return r;
    endfunction

    task automatic filter_byte(input t_rx_in item, input logic typed_short);
        t_rx_out     r;
        logic [7:0]  older;
        logic [7:0]  newer;
        logic [15:0] fc;
        logic [15:0] pan;
        logic [15:0] dst;
        logic [15:0] fcs;
        logic [2:0]  st;
        int          plen;
        older = delay_q[1];
        newer = delay_q[0];
        if (byte_pos >= 2) begin
            crc_acc = crc16_update(crc_acc, older);
        end
        if (byte_pos >= MIN_FRAME_LEN && byte_pos <= LAST_PAY_POS) begin
            r = '0;
            r.item_kind    = KIND_PAYLOAD;
            r.payload_byte = older;
            rx_items_due.push_back(r);
        end
        if (byte_pos < HEADER_LEN) begin
            hdr_q[byte_pos] = item.in_byte;
        end
        delay_q[1] = newer;
        delay_q[0] = item.in_byte;
        if (item.last_byte) begin
            r = '0;
            r.item_kind = KIND_SUMMARY;
            plen = int'(byte_pos) + 1 - MIN_FRAME_LEN;
            if (plen < 0) begin
                r.status = ST_SHORT;
            end else begin
                fc  = {hdr_q[1], hdr_q[0]};
                pan = {hdr_q[4], hdr_q[3]};
                dst = {hdr_q[6], hdr_q[5]};
                fcs = {item.in_byte, newer};
                if (byte_pos == POS_MAX || plen > MAX_PAYLOAD) begin
                    st = ST_TOO_LONG;
                end else if (fcs != crc_acc) begin
                    st = ST_FCS_ERR;
                end else if (pan != own_pan_q && pan != BROADCAST_ID) begin
                    st = ST_PAN_MISS;
                end else if (dst != own_addr_q && dst != BROADCAST_ID) begin
                    st = ST_DST_MISS;
                end else begin
                    st = ST_OK;
                end
                r.status        = st;
                r.frame_control = fc;
                r.seq_number    = hdr_q[2];
                r.frame_pan     = pan;
                r.frame_dst     = dst;
                r.frame_src     = {hdr_q[8], hdr_q[7]};
                r.payload_count = (plen > MAX_PAYLOAD) ? COUNT_W'(MAX_PAYLOAD)
                                                       : COUNT_W'(plen);
                r.frame_check   = fcs;
                r.ack_request   = (st == ST_OK) && fc[ACK_REQ_BIT];
                r.ack_check     = crc16_update(crc16_update(crc16_update(
                                      CRC_INIT, 8'h02), 8'h00), hdr_q[2]);
            end
            if (typed_short) begin
                r = short_summary();
            end
            rx_items_due.push_back(r);
            byte_pos = '0;
            crc_acc  = CRC_INIT;
        end else if (byte_pos != POS_MAX) begin
            byte_pos = byte_pos + 1'b1;
        end
    endtask

    task automatic check_result(input t_rx_out want, input t_rx_out got);
        if (got.item_kind !== want.item_kind) begin
            $error("item_kind: expected %0h, got %0h", want.item_kind, got.item_kind);
            error_count++;
        end
        if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h",
                   want.payload_byte, got.payload_byte);
            error_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, got.status);
            error_count++;
        end
        if (got.frame_control !== want.frame_control) begin
            $error("frame_control: expected %0h, got %0h",
                   want.frame_control, got.frame_control);
            error_count++;
        end
        if (got.seq_number !== want.seq_number) begin
            $error("seq_number: expected %0h, got %0h", want.seq_number, got.seq_number);
            error_count++;
        end
        if (got.frame_pan !== want.frame_pan) begin
            $error("frame_pan: expected %0h, got %0h", want.frame_pan, got.frame_pan);
            error_count++;
        end
        if (got.frame_dst !== want.frame_dst) begin
            $error("frame_dst: expected %0h, got %0h", want.frame_dst, got.frame_dst);
            error_count++;
        end
        if (got.frame_src !== want.frame_src) begin
            $error("frame_src: expected %0h, got %0h", want.frame_src, got.frame_src);
            error_count++;
        end
        if (got.payload_count !== want.payload_count) begin
            $error("payload_count: expected %0d, got %0d",
                   want.payload_count, got.payload_count);
            error_count++;
        end
        if (got.frame_check !== want.frame_check) begin
            $error("frame_check: expected %0h, got %0h",
                   want.frame_check, got.frame_check);
            error_count++;
        end
        if (got.ack_request !== want.ack_request) begin
            $error("ack_request: expected %0h, got %0h",
                   want.ack_request, got.ack_request);
            error_count++;
        end
        if (got.ack_check !== want.ack_check) begin
            $error("ack_check: expected %0h, got %0h", want.ack_check, got.ack_check);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (rx_items_due.size() == 0) begin
                    $error("unexpected result transfer: %h", o_out_data);
                    error_count++;
                end else begin
                    check_result(rx_items_due.pop_front(), o_out_data);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                filter_byte(i_in_data, short_end_mark);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: a random stall before each transfer, with calm stretches.
    initial begin : result_sink
        int hold;
        bit out_calm;
        out_calm    = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                out_calm = !out_calm;
            end
            hold = out_calm ? 0 : $urandom_range(0, 16);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic typed_short, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data      = {b, lst};
        short_end_mark = typed_short;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (rx_items_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [15:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = {16'h0000, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_OWN_PAN) begin
            own_pan_q = value;
        end else begin
            own_addr_q = value;
        end
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0000, value}) begin
            $error("prdata: expected %0h, got %0h", {16'h0000, value}, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [15:0] pick_id(input logic [15:0] own);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return own;
        end else if (r < 8) begin
            return BROADCAST_ID;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Builds one frame of the given length and sends it. Noise frames are
    // random bytes throughout; the others, if at least MIN_FRAME_LEN long,
    // carry a plausible header and, mostly, a correct FCS.
    task automatic send_frame(input int len, input bit noise);
        logic [7:0]  fr [MAX_FRAME];
        logic [15:0] fc;
        logic [15:0] pan;
        logic [15:0] dst;
        logic [15:0] src;
        logic [15:0] fcs;
        bit          calm;
        calm = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            fr[i] = 8'($urandom_range(0, 255));
        end
        if (!noise && len >= MIN_FRAME_LEN) begin
            fc  = 16'($urandom_range(0, 65535));
            pan = pick_id(own_pan_q);
            dst = pick_id(own_addr_q);
            src = 16'($urandom_range(0, 65535));
            {fr[1], fr[0]} = fc;
            {fr[4], fr[3]} = pan;
            {fr[6], fr[5]} = dst;
            {fr[8], fr[7]} = src;
            fcs = CRC_INIT;
            for (int i = 0; i < len - 2; i++) begin
                fcs = crc16_update(fcs, fr[i]);
            end
            if ($urandom_range(0, 9) == 0) begin
                fcs = fcs ^ 16'($urandom_range(1, 65535));
            end
            {fr[len-1], fr[len-2]} = fcs;
        end
        for (int i = 0; i < len; i++) begin
            send_byte(fr[i], (i == len - 1), 1'b0, calm);
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return $urandom_range(1, MIN_FRAME_LEN - 1);
        end else if (r < 14) begin
            case ($urandom_range(0, 3))
                0: return MIN_FRAME_LEN;
                1: return MIN_FRAME_LEN + 1;
                2: return MIN_FRAME_LEN + MAX_PAYLOAD;
                default: return MIN_FRAME_LEN + MAX_PAYLOAD + 1;
            endcase
        end else if (r < 20) begin
            return $urandom_range(100, 140);
        end
        return $urandom_range(MIN_FRAME_LEN, 40);
    endfunction

    initial begin : stimulus
        logic [15:0] pan_setting;
        logic [15:0] addr_setting;
        int          phase_start;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        short_end_mark = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        own_pan_q      = '0;
        own_addr_q     = '0;
        byte_pos       = '0;
        crc_acc        = CRC_INIT;
        delay_q        = '{default: '0};
        hdr_q          = '{default: '0};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_byte(DIRECTED_ROWS[i][9:2], DIRECTED_ROWS[i][1], DIRECTED_ROWS[i][0],
                      (i < 11));
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    pan_setting  = 16'h0000;
                    addr_setting = 16'h0000;
                end
                1: begin
                    pan_setting  = 16'hFFFF;
                    addr_setting = 16'hFFFF;
                end
                2: begin
                    pan_setting  = 16'($urandom_range(0, 65535));
                    addr_setting = 16'($urandom_range(0, 65535));
                end
                default: begin
                    pan_setting  = 16'hFFFE;
                    addr_setting = 16'h0001;
                end
            endcase
            wait_idle();
            write_reg(ADDR_OWN_PAN, pan_setting);
            write_reg(ADDR_OWN_ADDR, addr_setting);
            phase_start = bytes_sent;
            if (phase == 2) begin
                send_frame($urandom_range(256, 270), 1'b0);
            end
            while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_frame($urandom_range(1, 40), 1'b1);
                end else begin
                    send_frame(pick_length(), 1'b0);
                end
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
